>>> sv/enbb_pkg.sv
// Package for the edge-normalised box blur.
// Holds item types, controller states, command/status structs and register codes.
// Used by every module of the block; depends on nothing.
package enbb_pkg;

    localparam int CH_W  = 8;
    localparam int REG_W = 12;

    localparam logic [REG_W-1:0] SIZE_RESET = 12'd64;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic            action;
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            frame_last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_LOAD,
        S_DIV
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic div_start;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic scan_last;
        logic div_done;
    } t_status;

endpackage

>>> sv/enbb_div.sv
// Iterative divider for the three window sums, one quotient bit per cycle.
// Quotients are means of 8-bit channels, so eight steps suffice.
// Depends on enbb_pkg.
module enbb_div #(
    parameter int SW = 15,
    parameter int HW = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2:0][SW-1:0]                i_sum,
    input  logic [HW-1:0]                     i_den,
    output logic [2:0][enbb_pkg::CH_W-1:0]    o_q,
    output logic                              o_done
);
    localparam int DW = SW + enbb_pkg::CH_W;

    logic [2:0][SW-1:0]             r_rem, n_rem;
    logic [2:0][enbb_pkg::CH_W-1:0] r_q, n_q;
    logic [HW-1:0]                  r_den;
    logic [2:0]                     r_bit;
    logic                           r_busy;
    logic [DW-1:0]                  cand;

    assign cand   = DW'(r_den) << r_bit;
    assign o_done = r_busy && (r_bit == 3'd0);
    assign o_q    = r_q;

    // trial subtract on each lane
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        for (int k = 0; k < 3; k++) begin
            if (DW'(r_rem[k]) >= cand) begin
                n_rem[k]        = SW'(DW'(r_rem[k]) - cand);
                n_q[k][r_bit]   = 1'b1;
            end
        end
    end

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_bit  <= 3'd7;
        end else if (r_busy) begin
            if (r_bit == 3'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_bit <= r_bit - 3'd1;
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_sum;
            r_q   <= '0;
            r_den <= (i_den == '0) ? HW'(1) : i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

endmodule

>>> sv/enbb_dp.sv
// Datapath: size registers, frame counters, line store, window scan and sums.
// Instantiates enbb_div; driven by enbb_ctrl through t_cmd / t_status.
// Depends on enbb_pkg.
module enbb_dp #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int RADIUS     = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  enbb_pkg::t_cmd              i_cmd,
    output enbb_pkg::t_status           o_status,
    input  enbb_pkg::t_in_item          i_item,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [enbb_pkg::REG_W-1:0]  i_cfg_data,
    output enbb_pkg::t_out_item         o_item
);
    localparam int SLOTS = 2 * RADIUS + 2;
    localparam int SLW   = $clog2(SLOTS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SPAN  = 2 * RADIUS + 1;
    localparam int KW    = $clog2(SPAN);
    localparam int HW    = $clog2(SPAN * SPAN + 1);
    localparam int SW    = $clog2(SPAN * SPAN * 255 + 1);
    localparam int DEPTH = SLOTS * (2 ** XW);
    localparam int PW    = 3 * enbb_pkg::CH_W;

    logic [enbb_pkg::REG_W-1:0] r_w_reg, r_h_reg;
    logic [CW-1:0]  w;
    logic [RW-1:0]  h;
    logic [NW-1:0]  lag;

    logic [CW-1:0]  r_in_col, n_in_col, r_out_col, n_out_col, r_cx;
    logic [RW-1:0]  r_in_row, n_in_row, r_out_row, n_out_row, r_cy;
    logic [SLW-1:0] r_in_slot, n_in_slot, r_out_slot, n_out_slot, r_sslot;
    logic [NW-1:0]  r_n, n_n;
    logic           r_in_done, n_in_done;
    logic           r_last;
    logic           r_out_last;
    logic           wr, emit, last_now;
    logic           cfg_size;

    logic [KW-1:0]  r_dy, r_dx;
    logic           r_rd_v;
    logic [PW-1:0]  r_rd_data;
    logic [2:0][SW-1:0] r_sum;
    logic [HW-1:0]  r_hits;
    logic signed [RW+1:0] y;
    logic signed [CW+1:0] x;
    logic           inimg;
    logic [SLW+XW-1:0] rd_addr;

    logic [PW-1:0]  mem [DEPTH];

    logic [2:0][enbb_pkg::CH_W-1:0] q;
    logic           div_done;

    // clamp the size registers into range
    always_comb begin
        if (r_w_reg == '0) begin
            w = CW'(1);
        end else if (32'(r_w_reg) > 32'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_w_reg);
        end
        if (r_h_reg == '0) begin
            h = RW'(1);
        end else if (32'(r_h_reg) > 32'(MAX_HEIGHT)) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(r_h_reg);
        end
    end

    assign lag = NW'(RADIUS * 32'(w) + RADIUS);

    // decide what an accepted item does
    assign wr       = i_cmd.accept && !r_in_done && !i_item.action;
    assign emit     = r_in_done || (!i_item.action && (r_n >= lag));
    assign last_now = (r_out_row == h - RW'(1)) && (r_out_col == w - CW'(1));
    assign cfg_size = i_cfg_we
                   && (i_cfg_idx inside {enbb_pkg::CFG_WIDTH, enbb_pkg::CFG_HEIGHT});

    // advance input and output positions
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_in_slot  = r_in_slot;
        n_n        = r_n;
        n_in_done  = r_in_done;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_out_slot = r_out_slot;
        if (wr) begin
            n_n = r_n + NW'(1);
            if (r_in_col + CW'(1) >= w) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + RW'(1);
                n_in_slot = (r_in_slot == SLW'(SLOTS - 1)) ? '0 : r_in_slot + SLW'(1);
                if (r_in_row + RW'(1) >= h) begin
                    n_in_done = 1'b1;
                end
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (i_cmd.accept && emit) begin
            if (r_out_col + CW'(1) >= w) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + RW'(1);
                n_out_slot = (r_out_slot == SLW'(SLOTS - 1)) ? '0 : r_out_slot + SLW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
        // restart the frame after its last result or on a size write
        if ((i_cmd.accept && emit && last_now) || cfg_size) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_in_slot  = '0;
            n_n        = '0;
            n_in_done  = 1'b0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_out_slot = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_reg    <= enbb_pkg::SIZE_RESET;
            r_h_reg    <= enbb_pkg::SIZE_RESET;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_n        <= '0;
            r_in_done  <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_rd_v     <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == enbb_pkg::CFG_WIDTH) begin
                r_w_reg <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == enbb_pkg::CFG_HEIGHT) begin
                r_h_reg <= i_cfg_data;
            end
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_in_slot  <= n_in_slot;
            r_n        <= n_n;
            r_in_done  <= n_in_done;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_out_slot <= n_out_slot;
            r_rd_v     <= i_cmd.scan_step && inimg;
        end
    end

    // window position under scan
    always_comb begin
        y = $signed({2'b00, r_cy}) - $signed((RW+2)'(RADIUS))
            + $signed((RW+2)'(r_dy));
        x = $signed({2'b00, r_cx}) - $signed((CW+2)'(RADIUS))
            + $signed((CW+2)'(r_dx));
        inimg = (y >= 0) && (y < $signed({2'b00, h}))
             && (x >= 0) && (x < $signed({2'b00, w}));
        rd_addr = {r_sslot, x[XW-1:0]};
    end

    // line store: write the pixel, read one window position a cycle
    always_ff @(posedge i_clk) begin
        if (wr) begin
            mem[{r_in_slot, r_in_col[XW-1:0]}] <= {i_item.red_in, i_item.green_in,
                                                  i_item.blue_in};
        end
        if (i_cmd.scan_step) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // scan counters, centre and sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && emit) begin
            r_cx    <= r_out_col;
            r_cy    <= r_out_row;
            r_last  <= last_now;
            r_sslot <= (r_out_slot >= SLW'(RADIUS)) ? r_out_slot - SLW'(RADIUS)
                                                   : r_out_slot + SLW'(SLOTS - RADIUS);
            r_dy    <= '0;
            r_dx    <= '0;
            r_sum   <= '0;
            r_hits  <= '0;
        end else begin
            if (i_cmd.scan_step) begin
                if (r_dx == KW'(SPAN - 1)) begin
                    r_dx    <= '0;
                    r_dy    <= r_dy + KW'(1);
                    r_sslot <= (r_sslot == SLW'(SLOTS - 1)) ? '0 : r_sslot + SLW'(1);
                end else begin
                    r_dx <= r_dx + KW'(1);
                end
            end
            if (r_rd_v) begin
                r_sum[2] <= r_sum[2] + SW'(r_rd_data[PW-1:2*enbb_pkg::CH_W]);
                r_sum[1] <= r_sum[1] + SW'(r_rd_data[2*enbb_pkg::CH_W-1:enbb_pkg::CH_W]);
                r_sum[0] <= r_sum[0] + SW'(r_rd_data[enbb_pkg::CH_W-1:0]);
                r_hits   <= r_hits + HW'(1);
            end
        end
    end

    // hold the last-pixel flag with the quotients in the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_out_last <= r_last;
        end
    end

    enbb_div #(
        .SW (SW),
        .HW (HW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_sum   (r_sum),
        .i_den   (r_hits),
        .o_q     (q),
        .o_done  (div_done)
    );

    // status and result
    always_comb begin
        o_status.emit      = emit;
        o_status.scan_last = (r_dx == KW'(SPAN - 1)) && (r_dy == KW'(SPAN - 1));
        o_status.div_done  = div_done;
        o_item.red_out     = q[2];
        o_item.green_out   = q[1];
        o_item.blue_out    = q[0];
        o_item.frame_last  = r_out_last;
    end

endmodule

>>> sv/enbb_ctrl.sv
// Controller: accepts items, sequences the window scan, division and result hand-off.
// Talks to enbb_dp through t_cmd / t_status only.
// Depends on enbb_pkg.
module enbb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_stall,
    input  enbb_pkg::t_status  i_status,
    output enbb_pkg::t_cmd     o_cmd,
    output logic               o_in_stall,
    output logic               o_out_valid
);
    enbb_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // the output register can take a new result this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            enbb_pkg::S_IDLE: begin
                if (i_in_valid && i_status.emit) begin
                    n_state = enbb_pkg::S_SCAN;
                end
            end
            enbb_pkg::S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = enbb_pkg::S_FLUSH;
                end
            end
            enbb_pkg::S_FLUSH: n_state = enbb_pkg::S_LOAD;
            enbb_pkg::S_LOAD: begin
                if (out_free) begin
                    n_state = enbb_pkg::S_DIV;
                end
            end
            enbb_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    n_state = enbb_pkg::S_IDLE;
                end
            end
            default: n_state = enbb_pkg::S_IDLE;
        endcase
    end

    // hold a finished result until the receiver takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == enbb_pkg::S_DIV && i_status.div_done) begin
            n_out_valid = 1'b1;
        end
    end

    // outputs
    always_comb begin
        o_cmd.accept    = (r_state == enbb_pkg::S_IDLE) && i_in_valid;
        o_cmd.scan_step = (r_state == enbb_pkg::S_SCAN);
        o_cmd.div_start = (r_state == enbb_pkg::S_LOAD) && out_free;
        o_in_stall      = (r_state != enbb_pkg::S_IDLE);
        o_out_valid     = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= enbb_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_flush_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == enbb_pkg::S_SCAN && i_status.scan_last) |=> r_state == enbb_pkg::S_FLUSH)
        else $error("scan did not end in flush");
    a_div_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == enbb_pkg::S_DIV) |-> $past(r_state == enbb_pkg::S_LOAD))
        else $error("division entered without load");
    a_no_emit_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_status.emit) |=> r_state == enbb_pkg::S_IDLE)
        else $error("item without result left idle");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

>>> sv/edge_normalized_box_blur.sv
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_in_item  (enbb_pkg::t_in_item)
// output    o_out_valid   i_out_stall   o_out_item (enbb_pkg::t_out_item)
// config    i_cfg_we      -             i_cfg_idx, i_cfg_data
//
// An item without a result does not stall the input. An item with a result holds
// the input while the window is read from the line store one position a cycle, then
// an eight-step divider forms the means.
// The result then waits in the output register while further items are taken; an
// item with a result waits before its division while that register is full and stalled.
// Reset is synchronous, active low; sizes return to 64 and the frame restarts.
// Top level of the edge-normalised box blur; depends on enbb_pkg, enbb_ctrl, enbb_dp.
module edge_normalized_box_blur #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int RADIUS     = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  enbb_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output enbb_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [enbb_pkg::REG_W-1:0]  i_cfg_data
);
    enbb_pkg::t_cmd    cmd;
    enbb_pkg::t_status status;

    enbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    enbb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RADIUS     (RADIUS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_item     (o_out_item)
    );

endmodule
